// ===== rtl/core/fwwb_pkg.sv =====
// shared types and constants for the forward-window weighted blur
// no dependencies; imported by the top level

package fwwb_pkg;

  // image geometry
  localparam int MAX_SIZE = 1024;
  localparam int ADDR_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 11;

  // pixel and line store layout
  localparam int CH_W   = 16;
  localparam int PIX_W  = 3 * CH_W;
  localparam int LINE_W = 2 * PIX_W;

  // right shift per window tap [row][col]; zero marks a tap of weight zero
  localparam int unsigned TAP_SHIFT [3][3] = '{'{1, 5, 0}, '{5, 2, 5}, '{0, 5, 3}};

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_red;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_blue;
    logic [ADDR_W-1:0] out_row;
    logic [ADDR_W-1:0] out_col;
    logic              run_end;
  } out_word_t;

endpackage

// ===== rtl/core/fwwb_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module fwwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/forward_window_weighted_blur_top.sv =====
// forward-window 3x3 weighted blur over a square rgb image in raster order
// uses fwwb_pkg and fwwb_ram (one ram holds both line stores)

// The block takes one pixel word per clock and blurs each pixel with the 3x3
// window that reaches down and right from it (weights 1/2, 1/32, 1/4, 1/8,
// zero weight on the two off corners, taps past the border skipped). A
// result leaves once its window is complete: a pixel inside the image
// releases at most one result, the last pixel of a row or any pixel of the
// last row up to three and the last pixel of the image up to nine, each with
// its row, column and a run_end flag on the last one. Results leave one per
// clock while out_stall is low, from a single output register, so a pixel
// releasing several results holds the input stalled until its last result
// is taken; otherwise the rate is one pixel per clock. A pixel passes the
// read stage, the emit stage and the output register in turn. The two line
// stores share one 1024 x 96 ram, read as the pixel is accepted and written
// back when the pixel leaves the read stage; a read of the entry being
// written is forwarded. The ram needs no clearing pass. A write of image_size
// (0 acts as 1, above 1024 acts as 1024) restarts the frame at the origin.

module forward_window_weighted_blur_top import fwwb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  // image size register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  // size register and position counters
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0] size_m1;
  logic [ADDR_W-1:0] row_r, row_nxt;
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic              cfg_wr;
  logic              in_acc;

  // read stage
  logic              s1_valid_r;
  pix_t              s1_pix_r;
  logic [ADDR_W-1:0] s1_row_r;
  logic [ADDR_W-1:0] s1_col_r;
  logic              s1_lrow_r;
  logic              s1_lcol_r;
  logic              fwd_r;
  logic [LINE_W-1:0] fwd_line_r;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] ram_wdata;
  pix_t              older;
  pix_t              newer;
  pix_t              cur;
  pix_t              wreg_r [3][2];
  pix_t              win1 [3][3];
  logic              s1_adv;
  logic              s1_has_out;
  logic              has_r;
  logic              has_c;
  logic [1:0]        a_lo;
  logic [1:0]        a_hi;
  logic [1:0]        b_lo;
  logic [1:0]        b_hi;

  // emit stage
  logic              s2_valid_r;
  pix_t              s2_win_r [3][3];
  logic [ADDR_W-1:0] s2_row_r;
  logic [ADDR_W-1:0] s2_col_r;
  logic [1:0]        a_lo_r, a_hi_r, b_lo_r, b_hi_r;
  logic [1:0]        a_r, a_nxt;
  logic [1:0]        b_r, b_nxt;
  logic              s2_last;
  logic              s2_take;
  logic              emit;
  logic [CH_W-1:0]   sum_red, sum_green, sum_blue;

  // output register
  logic              out_valid_r;
  out_word_t         out_data_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && !in_stall;
  assign size_m1   = ADDR_W'(size_r - SIZE_W'(1));

  // effective size on write, clamped to 1..MAX_SIZE
  always_comb begin
    size_nxt = size_r;
    if (cfg_wr) begin
      if (cfg_data == '0) begin
        size_nxt = SIZE_W'(1);
      end else if (cfg_data > SIZE_W'(MAX_SIZE)) begin
        size_nxt = SIZE_W'(MAX_SIZE);
      end else begin
        size_nxt = cfg_data;
      end
    end
  end

  // raster position of the next pixel
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (col_r == size_m1) begin
        col_nxt = '0;
        row_nxt = (row_r == size_m1) ? '0 : row_r + ADDR_W'(1);
      end else begin
        col_nxt = col_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(MAX_SIZE);
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      size_r <= size_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  // line store ram: {older row, newer row} per column
  fwwb_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_SIZE)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign line      = fwd_r ? fwd_line_r : ram_rdata;
  assign older     = pix_t'(line[LINE_W-1:PIX_W]);
  assign newer     = pix_t'(line[PIX_W-1:0]);
  assign ram_wdata = {newer, s1_pix_r};
  assign cur       = '{red: in_data.in_red, green: in_data.in_green, blue: in_data.in_blue};

  // read stage capture, forward a same-column write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= cur;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_lrow_r  <= (row_r == size_m1);
      s1_lcol_r  <= (col_r == size_m1);
      fwd_r      <= s1_adv && (s1_col_r == col_r);
      fwd_line_r <= ram_wdata;
    end
  end

  // current 3x3 window: rows r-2..r, columns c-2..c
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win1[k][0] = wreg_r[k][0];
      win1[k][1] = wreg_r[k][1];
    end
    win1[0][2] = older;
    win1[1][2] = newer;
    win1[2][2] = s1_pix_r;
  end

  // window offsets of the results this pixel completes
  always_comb begin
    if (s1_lrow_r) begin
      has_r = 1'b1;
      a_hi  = 2'd2;
      if (s1_row_r >= ADDR_W'(2)) begin
        a_lo = 2'd0;
      end else if (s1_row_r == ADDR_W'(1)) begin
        a_lo = 2'd1;
      end else begin
        a_lo = 2'd2;
      end
    end else begin
      has_r = (s1_row_r >= ADDR_W'(2));
      a_lo  = 2'd0;
      a_hi  = 2'd0;
    end
    if (s1_lcol_r) begin
      has_c = 1'b1;
      b_hi  = 2'd2;
      if (s1_col_r >= ADDR_W'(2)) begin
        b_lo = 2'd0;
      end else if (s1_col_r == ADDR_W'(1)) begin
        b_lo = 2'd1;
      end else begin
        b_lo = 2'd2;
      end
    end else begin
      has_c = (s1_col_r >= ADDR_W'(2));
      b_lo  = 2'd0;
      b_hi  = 2'd0;
    end
  end

  assign s1_has_out = has_r && has_c;
  assign emit       = s2_valid_r && (!out_valid_r || !out_stall);
  assign s2_last    = (a_r == a_hi_r) && (b_r == b_hi_r);
  assign s2_take    = !s2_valid_r || (emit && s2_last);
  assign s1_adv     = s1_valid_r && (!s1_has_out || s2_take);
  assign in_stall   = s1_valid_r && !s1_adv;

  // shift the window columns along
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        wreg_r[k][0] <= win1[k][1];
        wreg_r[k][1] <= win1[k][2];
      end
    end
  end

  // emit stage walk order: column offset inner, row offset outer
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (b_r == b_hi_r) begin
      b_nxt = b_lo_r;
      a_nxt = a_r + 2'd1;
    end else begin
      b_nxt = b_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv && s1_has_out) begin
      s2_valid_r <= 1'b1;
    end else if (emit && s2_last) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_out) begin
      s2_win_r <= win1;
      s2_row_r <= s1_row_r;
      s2_col_r <= s1_col_r;
      a_lo_r   <= a_lo;
      a_hi_r   <= a_hi;
      b_lo_r   <= b_lo;
      b_hi_r   <= b_hi;
      a_r      <= a_lo;
      b_r      <= b_lo;
    end else if (emit) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  // weighted sum for the result at offsets (a, b); max is 65529, fits 16 bits
  always_comb begin
    logic [2:0] rr;
    logic [2:0] cc;
    pix_t       tap;
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        rr  = {1'b0, a_r} + 3'(dr);
        cc  = {1'b0, b_r} + 3'(dc);
        tap = s2_win_r[rr[1:0]][cc[1:0]];
        if (TAP_SHIFT[dr][dc] != 0 && rr <= 3'd2 && cc <= 3'd2) begin
          sum_red   = sum_red   + (tap.red   >> TAP_SHIFT[dr][dc]);
          sum_green = sum_green + (tap.green >> TAP_SHIFT[dr][dc]);
          sum_blue  = sum_blue  + (tap.blue  >> TAP_SHIFT[dr][dc]);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_red   <= sum_red;
      out_data_r.out_green <= sum_green;
      out_data_r.out_blue  <= sum_blue;
      out_data_r.out_row   <= s2_row_r + ADDR_W'(a_r) - ADDR_W'(2);
      out_data_r.out_col   <= s2_col_r + ADDR_W'(b_r) - ADDR_W'(2);
      out_data_r.run_end   <= s2_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // position counters stay inside the image
  a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_r} < size_r) && ({1'b0, col_r} < size_r))
    else $error("position counter outside image");

  // emit offsets stay inside the range loaded for the pixel
  a_offs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (a_r >= a_lo_r) && (a_r <= a_hi_r) && (b_r >= b_lo_r) && (b_r <= b_hi_r))
    else $error("emit offset out of range");

  // emit stage empties after its last result unless reloaded
  a_s2_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && s2_last && !(s1_adv && s1_has_out)) |=> !s2_valid_r)
    else $error("emit stage still busy after last result");
`endif

endmodule
